### rtl/assert_macros.svh
// Assertion macros used by the core RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/vnl_pkg.sv
// ----------------------------------------------------------------------------
// vnl_pkg
// Widths and defaults for the vector normalise and length core.
// ----------------------------------------------------------------------------
package vnl_pkg;

  localparam int FRAC_BITS_DEF = 16;  // fraction bits of the unit vector
  localparam int IN_W          = 31;  // signed Q14.16 component
  localparam int MAG_W         = 31;  // magnitude of a difference
  localparam int SUM_W         = 64;  // exact sum of squares
  localparam int LEN_W         = 32;  // Q16.16 length
  localparam int UNIT_W        = 18;  // unit component field

  localparam logic OP_NORM = 1'b0;    // normalise a
  localparam logic OP_DIFF = 1'b1;    // direction of a minus b

endpackage

### rtl/vec3_normalize_and_length_core.sv
// ----------------------------------------------------------------------------
// vec3_normalize_and_length_core
// Pipelined 3D vector normalise with exact integer length.
// ----------------------------------------------------------------------------
// Input channel: an item is taken on a rising edge with start high and busy
// low. busy is always low, so an item may be presented every cycle.
// in_operation selects a (normalise) or a - b (direction).
// Result channel: out_valid is high for one cycle with the unit vector,
// the Q16.16 length floor(sqrt(S)) and the zero-length flag. The receiver
// cannot stall the result and none is needed: the pipeline never backs up.
// Pipeline: 3 front stages (difference, squares, sum), 32 square-root stages
// (one root bit each), FRAC_BITS+1 divide stages (one quotient bit each, three
// dividers side by side) and one output register.
// Throughput: one item per cycle, set by the fully pipelined root and
// divide chains.
// Reset: synchronous, active low; clears all valid bits, so no result appears
// until items enter after reset. Data registers are not reset.
// A zero vector gives zero unit, zero length and out_zero_length high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vec3_normalize_and_length_core #(
  parameter int FRAC_BITS = vnl_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_operation,
  input  logic signed [vnl_pkg::IN_W-1:0]   in_a_x,
  input  logic signed [vnl_pkg::IN_W-1:0]   in_a_y,
  input  logic signed [vnl_pkg::IN_W-1:0]   in_a_z,
  input  logic signed [vnl_pkg::IN_W-1:0]   in_b_x,
  input  logic signed [vnl_pkg::IN_W-1:0]   in_b_y,
  input  logic signed [vnl_pkg::IN_W-1:0]   in_b_z,
  output logic                       out_valid,
  output logic signed [vnl_pkg::UNIT_W-1:0] out_unit_x,
  output logic signed [vnl_pkg::UNIT_W-1:0] out_unit_y,
  output logic signed [vnl_pkg::UNIT_W-1:0] out_unit_z,
  output logic [vnl_pkg::LEN_W-1:0]         out_length,
  output logic                       out_zero_length
);

  localparam int MW  = vnl_pkg::MAG_W;
  localparam int SW  = vnl_pkg::SUM_W;
  localparam int LW  = vnl_pkg::LEN_W;
  localparam int UW  = vnl_pkg::UNIT_W;
  localparam int RW  = LW + 3;                 // root remainder width
  localparam int NSQ = LW;                     // root stages
  localparam int QB  = FRAC_BITS + 1;          // quotient bits
  localparam int NW  = (QB > UW) ? QB : UW;    // negate width
  localparam int IN_W_L = vnl_pkg::IN_W + 1;

  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Stage 1: difference, sign and magnitude
  // --------------------------------------------------------------------------
  logic                 v1_r;
  logic [2:0]           sg1_r;
  logic [MW-1:0]        mg1_r [0:2];

  logic signed [IN_W_L-1:0] a_v [0:2];
  logic signed [IN_W_L-1:0] b_v [0:2];
  logic signed [IN_W_L-1:0] d_v [0:2];
  logic [IN_W_L-1:0]        m_v [0:2];

  always_comb begin
    a_v[0] = IN_W_L'(in_a_x);
    a_v[1] = IN_W_L'(in_a_y);
    a_v[2] = IN_W_L'(in_a_z);
    b_v[0] = IN_W_L'(in_b_x);
    b_v[1] = IN_W_L'(in_b_y);
    b_v[2] = IN_W_L'(in_b_z);
    for (int i = 0; i < 3; i++) begin
      d_v[i] = (in_operation == vnl_pkg::OP_DIFF) ? a_v[i] - b_v[i] : a_v[i];
      m_v[i] = d_v[i][IN_W_L-1] ? IN_W_L'(-d_v[i]) : IN_W_L'(d_v[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    for (int i = 0; i < 3; i++) begin
      sg1_r[i] <= d_v[i][IN_W_L-1];
      mg1_r[i] <= m_v[i][MW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: squares
  // --------------------------------------------------------------------------
  logic                 v2_r;
  logic [2:0]           sg2_r;
  logic [MW-1:0]        mg2_r [0:2];
  logic [2*MW-1:0]      sq2_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    sg2_r <= sg1_r;
    for (int i = 0; i < 3; i++) begin
      mg2_r[i] <= mg1_r[i];
      sq2_r[i] <= mg1_r[i] * mg1_r[i];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sum of squares and zero test
  // --------------------------------------------------------------------------
  logic [SW-1:0] sum_v;
  assign sum_v = SW'(sq2_r[0]) + SW'(sq2_r[1]) + SW'(sq2_r[2]);

  // Root chain registers, index k feeds root stage k
  logic          sv_r  [0:NSQ];
  logic [2:0]    ssg_r [0:NSQ];
  logic          sz_r  [0:NSQ];
  logic [MW-1:0] smg_r [0:NSQ][0:2];
  logic [SW-1:0] ss_r  [0:NSQ];
  logic [RW-1:0] srm_r [0:NSQ];
  logic [LW-1:0] srt_r [0:NSQ];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else begin
      sv_r[0] <= v2_r;
    end
    ssg_r[0] <= sg2_r;
    sz_r[0]  <= (sum_v == '0);
    for (int i = 0; i < 3; i++) smg_r[0][i] <= mg2_r[i];
    ss_r[0]  <= sum_v;
    srm_r[0] <= '0;
    srt_r[0] <= '0;
  end

  // --------------------------------------------------------------------------
  // Square root: one root bit per stage, two radicand bits shifted in
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    logic [RW-1:0] cur_v, trial_v;
    logic          ge_v;
    assign cur_v   = {srm_r[k][RW-3:0], ss_r[k][SW-1 -: 2]};
    assign trial_v = {1'b0, srt_r[k], 2'b01};
    assign ge_v    = (cur_v >= trial_v);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else begin
        sv_r[k+1] <= sv_r[k];
      end
      ssg_r[k+1] <= ssg_r[k];
      sz_r[k+1]  <= sz_r[k];
      for (int i = 0; i < 3; i++) smg_r[k+1][i] <= smg_r[k][i];
      ss_r[k+1]  <= {ss_r[k][SW-3:0], 2'b00};
      srm_r[k+1] <= ge_v ? cur_v - trial_v : cur_v;
      srt_r[k+1] <= {srt_r[k][LW-2:0], ge_v};
    end
  end

  // --------------------------------------------------------------------------
  // Division: three restoring dividers, one quotient bit per stage
  // --------------------------------------------------------------------------
  logic          dv_r  [1:QB];
  logic [2:0]    dsg_r [1:QB];
  logic          dz_r  [1:QB];
  logic [LW-1:0] dl_r  [1:QB];
  logic [LW-1:0] drm_r [1:QB][0:2];
  logic [QB-1:0] dq_r  [1:QB][0:2];

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic          vi_v;
    logic [2:0]    sgi_v;
    logic          zi_v;
    logic [LW-1:0] li_v;
    logic [LW-1:0] rmi_v [0:2];
    logic [QB-1:0] qi_v  [0:2];
    logic [LW:0]   c_v   [0:2];
    logic          ge_v  [0:2];

    // Stage inputs: root chain for the first stage, previous stage otherwise
    if (j == 0) begin : g_src
      always_comb begin
        vi_v  = sv_r[NSQ];
        sgi_v = ssg_r[NSQ];
        zi_v  = sz_r[NSQ];
        li_v  = srt_r[NSQ];
        for (int i = 0; i < 3; i++) begin
          rmi_v[i] = LW'(smg_r[NSQ][i]);
          qi_v[i]  = '0;
        end
      end
    end else begin : g_src
      always_comb begin
        vi_v  = dv_r[j];
        sgi_v = dsg_r[j];
        zi_v  = dz_r[j];
        li_v  = dl_r[j];
        for (int i = 0; i < 3; i++) begin
          rmi_v[i] = drm_r[j][i];
          qi_v[i]  = dq_r[j][i];
        end
      end
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        c_v[i]  = (j == 0) ? {1'b0, rmi_v[i]} : {rmi_v[i], 1'b0};
        ge_v[i] = (c_v[i] >= {1'b0, li_v});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else begin
        dv_r[j+1] <= vi_v;
      end
      dsg_r[j+1] <= sgi_v;
      dz_r[j+1]  <= zi_v;
      dl_r[j+1]  <= li_v;
      for (int i = 0; i < 3; i++) begin
        drm_r[j+1][i] <= ge_v[i] ? LW'(c_v[i] - {1'b0, li_v}) : LW'(c_v[i]);
        dq_r[j+1][i]  <= {qi_v[i][QB-2:0], ge_v[i]};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: apply sign, mask zero vector
  // --------------------------------------------------------------------------
  logic [NW-1:0] uq_v [0:2];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      uq_v[i] = dsg_r[QB][i] ? NW'(-NW'(dq_r[QB][i])) : NW'(dq_r[QB][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_r[QB];
    end
    out_zero_length <= dz_r[QB];
    out_length      <= dz_r[QB] ? '0 : dl_r[QB];
    out_unit_x      <= dz_r[QB] ? '0 : uq_v[0][UW-1:0];
    out_unit_y      <= dz_r[QB] ? '0 : uq_v[1][UW-1:0];
    out_unit_z      <= dz_r[QB] ? '0 : uq_v[2][UW-1:0];
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_IMP(a_zero_len, clk, rst_n, out_valid && out_zero_length, out_length == '0, "zero len")
  `ASSERT_IMP(a_nz_len, clk, rst_n, out_valid && !out_zero_length, out_length != '0, "nz len")
  `ASSERT_NXT(a_out_pulse, clk, rst_n, dv_r[QB], out_valid, "result strobe lost")

endmodule
